// ----- src/sdne_pkg.sv -----
// shared types, constants and codes of the second-difference noise estimator
package sdne_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int INTERVAL_W  = 24;
   localparam int VAR_W       = 52;
   localparam int FILL_OUT_W  = 7;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;

   // sizes
   localparam int WINDOW_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH          = 2;

   // arithmetic widths
   localparam int RATIO_W = 32;
   localparam int DEN_W   = 67;
   localparam int MAG_W   = 50;
   localparam int HALF_W  = 25;
   localparam int SQ_W    = 98;

   localparam logic [32:0] ONE_Q18   = 33'd262144;
   localparam logic [66:0] ONE_Q36   = 67'd68719476736;
   localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
   localparam logic [51:0] VAR_MAX   = 52'hF_FFFF_FFFF_FFFF;

   // register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  MIN_INTERVAL_RESET = 24'd100;
   localparam logic [CSR_DATA_W-1:0]  MAX_INTERVAL_RESET = 24'd1000000;

   typedef enum logic {
      KIND_SAMPLE,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [SAMPLE_W-1:0]     sample_x;
      logic [SAMPLE_W-1:0]     sample_y;
      logic [SAMPLE_W-1:0]     sample_z;
      logic [INTERVAL_W-1:0]   interval_us;
   } item_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] min_interval_us;
      logic [INTERVAL_W-1:0] max_interval_us;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RATIO,
      S_RDIV,
      S_DEN_SQ,
      S_DEN_SUM,
      S_PROD,
      S_DIFF,
      S_SQ,
      S_VSTART,
      S_VDIV,
      S_UPDATE,
      S_MSTART,
      S_MDIV,
      S_DONE
   } state_type;

endpackage

// ----- src/sdne_ram.sv -----
// generic single-port-write ram with registered read
module sdne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sdne_front.sv -----
// input stage: takes request transfers, classifies them and pushes to the queue
module sdne_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [sdne_pkg::SAMPLE_W-1:0]  req_sample_x,
   input  logic [sdne_pkg::SAMPLE_W-1:0]  req_sample_y,
   input  logic [sdne_pkg::SAMPLE_W-1:0]  req_sample_z,
   input  logic [sdne_pkg::INTERVAL_W-1:0] req_interval_us,
   output logic                           push,
   output sdne_pkg::item_type             push_item,
   input  logic                           queue_full
);

   logic               hold_valid_ff, hold_valid_in;
   sdne_pkg::item_type hold_item_ff, hold_item_in;
   logic               accept;

   // holding register drains into the queue whenever there is room
   always_comb begin
      req_stall     = hold_valid_ff && queue_full;
      accept        = req_valid && !req_stall;
      push          = hold_valid_ff && !queue_full;
      push_item     = hold_item_ff;
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in            = 1'b1;
         hold_item_in.kind        = req_cmd ? sdne_pkg::KIND_CLEAR : sdne_pkg::KIND_SAMPLE;
         hold_item_in.sample_x    = req_sample_x;
         hold_item_in.sample_y    = req_sample_y;
         hold_item_in.sample_z    = req_sample_z;
         hold_item_in.interval_us = req_interval_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

// ----- src/sdne_queue.sv -----
// short item queue between the input stage and the compute engine
module sdne_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdne_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output sdne_pkg::item_type pop_item
);

   localparam int PTR_W = $clog2(sdne_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sdne_pkg::QUEUE_DEPTH + 1);

   sdne_pkg::item_type entries_ff [sdne_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer and occupancy update
   always_comb begin
      full      = count_ff == CNT_W'(sdne_pkg::QUEUE_DEPTH);
      empty     = count_ff == '0;
      pop_item  = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sdne_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sdne_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/sdne_back.sv -----
// compute engine: second difference, shared serial divider, window and means
module sdne_back #(
   parameter int WINDOW_DEPTH = sdne_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sdne_pkg::cfg_type               cfg,
   input  logic                            queue_empty,
   input  sdne_pkg::item_type              queue_item,
   output logic                            queue_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sdne_pkg::VAR_W-1:0]      rsp_variance_x,
   output logic [sdne_pkg::VAR_W-1:0]      rsp_variance_y,
   output logic [sdne_pkg::VAR_W-1:0]      rsp_variance_z,
   output logic [sdne_pkg::FILL_OUT_W-1:0] rsp_window_fill
);

   localparam int VW      = sdne_pkg::VAR_W;
   localparam int SW      = sdne_pkg::SAMPLE_W;
   localparam int IW      = sdne_pkg::INTERVAL_W;
   localparam int DW      = sdne_pkg::DEN_W;
   localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
   localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W   = VW + $clog2(WINDOW_DEPTH);
   localparam int QW      = SUM_W;
   localparam int CNT_W   = $clog2(QW + 1);
   localparam int ENTRY_W = 3 * VW;

   sdne_pkg::state_type state_ff, state_in;
   sdne_pkg::item_type  item_ff, item_in;
   logic [SW-1:0]       prev_ff [3];
   logic [SW-1:0]       prev_in [3];
   logic [SW-1:0]       old_ff [3];
   logic [SW-1:0]       old_in [3];
   logic [IW-1:0]       prev_int_ff, prev_int_in;
   logic [1:0]          seen_ff, seen_in;
   logic [31:0]         a_ff, a_in;
   logic [63:0]         aa_ff, aa_in;
   logic [65:0]         bb_ff, bb_in;
   logic [DW-1:0]       den_ff, den_in;
   logic [1:0]          axis_ff, axis_in;
   logic signed [49:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic [sdne_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic [sdne_pkg::SQ_W-1:0]  acc_ff, acc_in;
   logic [1:0]          sqc_ff, sqc_in;
   logic [DW-1:0]       div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [QW-1:0]       div_low_ff, div_low_in, div_q_ff, div_q_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                div_sat_ff, div_sat_in;
   logic [VW-1:0]       ent_ff [3];
   logic [VW-1:0]       ent_in [3];
   logic [SUM_W-1:0]    sum_ff [3];
   logic [SUM_W-1:0]    sum_in [3];
   logic [VW-1:0]       mean_ff [3];
   logic [VW-1:0]       mean_in [3];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]       out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [FILL_W-1:0]   out_fill_ff, out_fill_in;

   // window memory, one row holds the three axis entries
   logic               ram_we;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   // datapath helpers
   logic [32:0]          b_w;
   logic [IW-1:0]        ci_w, cp0_w, cp_w;
   logic [SW-1:0]        cur_w, prev_s, old_s;
   logic signed [51:0]   cur_ext, d_w;
   logic [sdne_pkg::HALF_W-1:0] mx_w, my_w;
   logic [49:0]          pp_w;
   logic [sdne_pkg::SQ_W-1:0] part_w;
   logic [DW:0]          r2_w, diff_w;
   logic                 ge_w;
   logic [DW-1:0]        rem_step;
   logic [61:0]          vtop_w;
   logic                 full_w;
   logic [VW-1:0]        old_ent [3];

   function automatic logic [IW-1:0] clamp_iv(input logic [IW-1:0] v,
                                               input logic [IW-1:0] mn,
                                               input logic [IW-1:0] mx);
      logic [IW-1:0] t;
      t = (v > mx) ? mx : v;
      return (t < mn) ? mn : t;
   endfunction

   sdne_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (ram_wdata),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   // shared arithmetic
   always_comb begin
      b_w   = {1'b0, a_ff} + sdne_pkg::ONE_Q18;
      ci_w  = clamp_iv(item_ff.interval_us, cfg.min_interval_us, cfg.max_interval_us);
      cp0_w = clamp_iv(prev_int_ff, cfg.min_interval_us, cfg.max_interval_us);
      cp_w  = (cp0_w == '0) ? IW'(1) : cp0_w;
      case (axis_ff)
         2'd0:    cur_w = item_ff.sample_x;
         2'd1:    cur_w = item_ff.sample_y;
         default: cur_w = item_ff.sample_z;
      endcase
      prev_s  = prev_ff[axis_ff];
      old_s   = old_ff[axis_ff];
      cur_ext = {{18{cur_w[SW-1]}}, cur_w, 18'd0};
      d_w     = cur_ext - 52'(p1_ff) + 52'(p2_ff);
      // one 25 x 25 partial product a cycle for the square of the magnitude
      case (sqc_ff)
         2'd0: begin
            mx_w = mag_ff[24:0];
            my_w = mag_ff[24:0];
         end
         2'd3: begin
            mx_w = mag_ff[49:25];
            my_w = mag_ff[49:25];
         end
         default: begin
            mx_w = mag_ff[24:0];
            my_w = mag_ff[49:25];
         end
      endcase
      pp_w = mx_w * my_w;
      case (sqc_ff)
         2'd0:    part_w = sdne_pkg::SQ_W'(pp_w);
         2'd3:    part_w = sdne_pkg::SQ_W'(pp_w) << 50;
         default: part_w = sdne_pkg::SQ_W'(pp_w) << 25;
      endcase
      // one restoring division step
      r2_w     = {div_rem_ff, div_low_ff[QW-1]};
      diff_w   = r2_w - {1'b0, div_den_ff};
      ge_w     = r2_w >= {1'b0, div_den_ff};
      rem_step = ge_w ? diff_w[DW-1:0] : r2_w[DW-1:0];
      vtop_w   = acc_ff[97:36];
      full_w   = fill_ff == FILL_W'(WINDOW_DEPTH);
      old_ent[0] = ram_rdata[VW-1:0];
      old_ent[1] = ram_rdata[2*VW-1:VW];
      old_ent[2] = ram_rdata[3*VW-1:2*VW];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prev_in      = prev_ff;
      old_in       = old_ff;
      prev_int_in  = prev_int_ff;
      seen_in      = seen_ff;
      a_in         = a_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      den_in       = den_ff;
      axis_in      = axis_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      sqc_in       = sqc_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_low_in   = div_low_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      div_sat_in   = div_sat_ff;
      ent_in       = ent_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_fill_in  = out_fill_ff;
      queue_pop    = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = {ent_ff[2], ent_ff[1], ent_ff[0]};

      case (state_ff)
         sdne_pkg::S_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               item_in   = queue_item;
               axis_in   = 2'd0;
               if (queue_item.kind == sdne_pkg::KIND_CLEAR) begin
                  seen_in = 2'd0;
                  fill_in = '0;
                  slot_in = '0;
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k]  = '0;
                     mean_in[k] = '0;
                  end
                  state_in = sdne_pkg::S_DONE;
               end else if (seen_ff < 2'd2) begin
                  // history fill only, window still empty
                  old_in      = prev_ff;
                  prev_in[0]  = queue_item.sample_x;
                  prev_in[1]  = queue_item.sample_y;
                  prev_in[2]  = queue_item.sample_z;
                  prev_int_in = queue_item.interval_us;
                  seen_in     = seen_ff + 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     mean_in[k] = '0;
                  end
                  state_in = sdne_pkg::S_DONE;
               end else begin
                  state_in = sdne_pkg::S_RATIO;
               end
            end
         end
         sdne_pkg::S_RATIO: begin
            if (prev_int_ff <= cfg.min_interval_us) begin
               a_in     = sdne_pkg::ONE_Q18[31:0];
               state_in = sdne_pkg::S_DEN_SQ;
            end else begin
               // ratio ci * 2^18 / cp, saturating above 32 bits
               div_rem_in = DW'(ci_w[23:14]);
               div_den_in = DW'(cp_w);
               div_sat_in = DW'(ci_w[23:14]) >= DW'(cp_w);
               div_low_in = {ci_w[13:0], {(QW-14){1'b0}}};
               div_q_in   = '0;
               div_cnt_in = CNT_W'(sdne_pkg::RATIO_W);
               state_in   = sdne_pkg::S_RDIV;
            end
         end
         sdne_pkg::S_RDIV: begin
            if (div_sat_ff || div_cnt_ff == '0) begin
               a_in     = div_sat_ff ? sdne_pkg::RATIO_MAX : div_q_ff[31:0];
               state_in = sdne_pkg::S_DEN_SQ;
            end else begin
               div_rem_in = rem_step;
               div_low_in = div_low_ff << 1;
               div_q_in   = {div_q_ff[QW-2:0], ge_w};
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         sdne_pkg::S_DEN_SQ: begin
            aa_in    = a_ff * a_ff;
            bb_in    = b_w * b_w;
            state_in = sdne_pkg::S_DEN_SUM;
         end
         sdne_pkg::S_DEN_SUM: begin
            den_in   = DW'(aa_ff) + DW'(bb_ff) + sdne_pkg::ONE_Q36;
            axis_in  = 2'd0;
            state_in = sdne_pkg::S_PROD;
         end
         sdne_pkg::S_PROD: begin
            p1_in    = $signed(prev_s) * $signed({1'b0, b_w});
            p2_in    = $signed(old_s) * $signed({1'b0, a_ff});
            state_in = sdne_pkg::S_DIFF;
         end
         sdne_pkg::S_DIFF: begin
            mag_in   = d_w[51] ? sdne_pkg::MAG_W'(-d_w) : sdne_pkg::MAG_W'(d_w);
            acc_in   = '0;
            sqc_in   = 2'd0;
            state_in = sdne_pkg::S_SQ;
         end
         sdne_pkg::S_SQ: begin
            acc_in = acc_ff + part_w;
            sqc_in = sqc_ff + 1'b1;
            if (sqc_ff == 2'd3) begin
               state_in = sdne_pkg::S_VSTART;
            end
         end
         sdne_pkg::S_VSTART: begin
            // d^2 * 2^16 / den, saturating above 52 bits
            div_rem_in = DW'(vtop_w);
            div_den_in = den_ff;
            div_sat_in = DW'(vtop_w) >= den_ff;
            div_low_in = {acc_ff[35:0], 16'd0, {(QW-VW){1'b0}}};
            div_q_in   = '0;
            div_cnt_in = CNT_W'(VW);
            state_in   = sdne_pkg::S_VDIV;
         end
         sdne_pkg::S_VDIV: begin
            if (div_sat_ff || div_cnt_ff == '0) begin
               ent_in[axis_ff] = div_sat_ff ? sdne_pkg::VAR_MAX : div_q_ff[VW-1:0];
               if (axis_ff == 2'd2) begin
                  state_in = sdne_pkg::S_UPDATE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = sdne_pkg::S_PROD;
               end
            end else begin
               div_rem_in = rem_step;
               div_low_in = div_low_ff << 1;
               div_q_in   = {div_q_ff[QW-2:0], ge_w};
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         sdne_pkg::S_UPDATE: begin
            // window write, running sums and history
            ram_we = 1'b1;
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = sum_ff[k] - (full_w ? SUM_W'(old_ent[k]) : '0) + SUM_W'(ent_ff[k]);
            end
            if (!full_w) begin
               fill_in = fill_ff + 1'b1;
            end
            slot_in     = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            old_in      = prev_ff;
            prev_in[0]  = item_ff.sample_x;
            prev_in[1]  = item_ff.sample_y;
            prev_in[2]  = item_ff.sample_z;
            prev_int_in = item_ff.interval_us;
            axis_in     = 2'd0;
            state_in    = sdne_pkg::S_MSTART;
         end
         sdne_pkg::S_MSTART: begin
            div_rem_in = '0;
            div_den_in = DW'(fill_ff);
            div_sat_in = 1'b0;
            div_low_in = sum_ff[axis_ff];
            div_q_in   = '0;
            div_cnt_in = CNT_W'(SUM_W);
            state_in   = sdne_pkg::S_MDIV;
         end
         sdne_pkg::S_MDIV: begin
            if (div_cnt_ff == '0) begin
               mean_in[axis_ff] = div_q_ff[VW-1:0];
               if (axis_ff == 2'd2) begin
                  state_in = sdne_pkg::S_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = sdne_pkg::S_MSTART;
               end
            end else begin
               div_rem_in = rem_step;
               div_low_in = div_low_ff << 1;
               div_q_in   = {div_q_ff[QW-2:0], ge_w};
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         sdne_pkg::S_DONE: begin
            // load the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_x_in     = mean_ff[0];
               out_y_in     = mean_ff[1];
               out_z_in     = mean_ff[2];
               out_fill_in  = fill_ff;
               state_in     = sdne_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sdne_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdne_pkg::S_IDLE;
         seen_ff      <= 2'd0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      item_ff     <= item_in;
      prev_ff     <= prev_in;
      old_ff      <= old_in;
      prev_int_ff <= prev_int_in;
      a_ff        <= a_in;
      aa_ff       <= aa_in;
      bb_ff       <= bb_in;
      den_ff      <= den_in;
      axis_ff     <= axis_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      sqc_ff      <= sqc_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_low_ff  <= div_low_in;
      div_q_ff    <= div_q_in;
      div_cnt_ff  <= div_cnt_in;
      div_sat_ff  <= div_sat_in;
      ent_ff      <= ent_in;
      mean_ff     <= mean_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_fill_ff <= out_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_variance_x  = out_x_ff;
   assign rsp_variance_y  = out_y_ff;
   assign rsp_variance_z  = out_z_ff;
   assign rsp_window_fill = sdne_pkg::FILL_OUT_W'(out_fill_ff);

`ifndef SYNTHESIS
   // window count never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_DEPTH))
      else $error("window count above depth");

   // nothing enters the window before two samples of history
   assert property (@(posedge clock) disable iff (reset)
      (seen_ff < 2'd2) |-> (fill_ff == '0))
      else $error("window filled without history");

   // while filling, the write slot tracks the count
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff != FILL_W'(WINDOW_DEPTH)) |-> (FILL_W'(slot_ff) == fill_ff))
      else $error("write slot out of step with window count");

   // an item is only taken from the queue when idle
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (state_ff == sdne_pkg::S_IDLE && !queue_empty))
      else $error("queue popped while busy or empty");
`endif

endmodule

// ----- src/imu_second_difference_noise_estimator_core.sv -----
// top level of the imu second-difference noise variance estimator
//
//  channel  direction  handshake         payload
//  req      in         req_valid/stall   cmd, sample_x/y/z, interval_us
//  rsp      out        rsp_valid/stall   variance_x/y/z, window_fill
//  csr      in         csr_we            csr_index, csr_wdata
//
//  a weighted-form sample runs its ratio, variance and mean divisions on the one
//  shared serial divider; the uniform form skips the ratio division
//  clear commands and the first two samples skip the divider
//  reset is synchronous; the window memory needs no clearing pass
//  the input stage and a two-entry queue keep taking transfers meanwhile
module imu_second_difference_noise_estimator_core #(
   parameter int WINDOW_DEPTH = sdne_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [sdne_pkg::SAMPLE_W-1:0]    req_sample_x,
   input  logic [sdne_pkg::SAMPLE_W-1:0]    req_sample_y,
   input  logic [sdne_pkg::SAMPLE_W-1:0]    req_sample_z,
   input  logic [sdne_pkg::INTERVAL_W-1:0]  req_interval_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sdne_pkg::VAR_W-1:0]       rsp_variance_x,
   output logic [sdne_pkg::VAR_W-1:0]       rsp_variance_y,
   output logic [sdne_pkg::VAR_W-1:0]       rsp_variance_z,
   output logic [sdne_pkg::FILL_OUT_W-1:0]  rsp_window_fill,
   input  logic                             csr_we,
   input  logic [sdne_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdne_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sdne_pkg::cfg_type  cfg_ff, cfg_in;
   logic               push, queue_full, queue_pop, queue_empty;
   sdne_pkg::item_type push_item, queue_item;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sdne_pkg::CSR_MIN_INTERVAL: cfg_in.min_interval_us = csr_wdata;
            sdne_pkg::CSR_MAX_INTERVAL: cfg_in.max_interval_us = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval_us <= sdne_pkg::MIN_INTERVAL_RESET;
         cfg_ff.max_interval_us <= sdne_pkg::MAX_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdne_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_sample_z    (req_sample_z),
      .req_interval_us (req_interval_us),
      .push            (push),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   sdne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_item  (queue_item)
   );

   sdne_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_empty     (queue_empty),
      .queue_item      (queue_item),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_variance_x  (rsp_variance_x),
      .rsp_variance_y  (rsp_variance_y),
      .rsp_variance_z  (rsp_variance_z),
      .rsp_window_fill (rsp_window_fill)
   );

endmodule
